>>> rtl/lens_distortion_point_mapper_macros.svh
// Assertion helpers for the RTL.
`ifndef LENS_DISTORTION_POINT_MAPPER_MACROS_SVH
`define LENS_DISTORTION_POINT_MAPPER_MACROS_SVH

// Checked outside reset.
`define LDPM_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define LDPM_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/ldpm_pkg.sv
`timescale 1ns / 1ps
package ldpm_pkg;

  localparam int VAL_W           = 64;
  localparam int HALF_W          = VAL_W / 2;
  localparam int PROD_W          = 2 * VAL_W;
  localparam int FRAC            = 32;
  localparam int COEF_W          = 20;
  localparam int COORD_W         = 32;
  localparam int SCALE_W         = 48;
  localparam int COORD_WIDTH_DEF = 32;
  localparam int CFG_DATA_W      = 64;
  localparam int CFG_ADDR_W      = 6;
  localparam int CFG_IDX_LSB     = 3;
  localparam int MUL_LAT         = 4;
  localparam int DIV_STEPS       = VAL_W;
  localparam int DIV_LAT         = MUL_LAT + DIV_STEPS + 1;

  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic [PROD_W-1:0]       prod_t;

  typedef struct packed {
    val_t val;
    logic sat;
  } res_t;

  typedef enum logic [2:0] {
    REG_MODE,
    REG_SCALE_U,
    REG_SCALE_V,
    REG_CENTER_U,
    REG_CENTER_V,
    REG_RADIAL_NUM,
    REG_RADIAL_DEN,
    REG_TANGENTIAL
  } reg_idx_t;

  localparam val_t VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam val_t VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  function automatic logic [VAL_W-1:0] mag(input val_t v);
    logic [VAL_W-1:0] r;
    r = v[VAL_W-1] ? (~v + 1'b1) : v;
    return r;
  endfunction

  // Magnitude plus sign back to a saturated signed value.
  function automatic res_t to_signed(input prod_t q, input logic neg);
    res_t r;
    logic hi_nz;
    hi_nz = |q[PROD_W-1:VAL_W];
    if (neg) begin
      if (hi_nz || (q[VAL_W-1:0] > VAL_MIN)) begin
        r.val = VAL_MIN;
        r.sat = 1'b1;
      end else begin
        r.val = ~q[VAL_W-1:0] + 1'b1;
        r.sat = 1'b0;
      end
    end else begin
      if (hi_nz || q[VAL_W-1]) begin
        r.val = VAL_MAX;
        r.sat = 1'b1;
      end else begin
        r.val = q[VAL_W-1:0];
        r.sat = 1'b0;
      end
    end
    return r;
  endfunction

endpackage

>>> rtl/ldpm_mul.sv
`timescale 1ns / 1ps
module ldpm_mul import ldpm_pkg::*; #(
  parameter int SHIFT = FRAC
) (
  input  logic  clk,
  input  logic  en,
  input  val_t  a,
  input  val_t  b,
  output prod_t prod,
  output logic  prod_neg,
  output res_t  res
);

  localparam prod_t REST_MASK = (prod_t'(1) << SHIFT) - prod_t'(1);

  logic [VAL_W-1:0] ma_r, mb_r;
  logic             neg1_r;
  logic [VAL_W-1:0] p00_r, p01_r, p10_r, p11_r;
  logic             neg2_r;
  prod_t            prod_r;
  logic             neg3_r;
  res_t             res_r;

  prod_t shifted, rounded;
  logic  rest;

  always_comb begin
    shifted = prod_r >> SHIFT;
    rest    = |(prod_r & REST_MASK);
    rounded = shifted + prod_t'(neg3_r & rest);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ma_r   <= mag(a);
      mb_r   <= mag(b);
      neg1_r <= a[VAL_W-1] ^ b[VAL_W-1];
      p00_r  <= ma_r[HALF_W-1:0] * mb_r[HALF_W-1:0];
      p01_r  <= ma_r[HALF_W-1:0] * mb_r[VAL_W-1:HALF_W];
      p10_r  <= ma_r[VAL_W-1:HALF_W] * mb_r[HALF_W-1:0];
      p11_r  <= ma_r[VAL_W-1:HALF_W] * mb_r[VAL_W-1:HALF_W];
      neg2_r <= neg1_r;
      prod_r <= {p11_r, {VAL_W{1'b0}}}
              + {{HALF_W{1'b0}}, p01_r, {HALF_W{1'b0}}}
              + {{HALF_W{1'b0}}, p10_r, {HALF_W{1'b0}}}
              + {{VAL_W{1'b0}}, p00_r};
      neg3_r <= neg2_r;
      res_r  <= to_signed(rounded, neg3_r);
    end
  end

  assign prod     = prod_r;
  assign prod_neg = neg3_r;
  assign res      = res_r;

endmodule

>>> rtl/ldpm_div.sv
`timescale 1ns / 1ps
module ldpm_div import ldpm_pkg::*; (
  input  logic clk,
  input  logic en,
  input  val_t a,
  input  val_t n,
  input  val_t d,
  output res_t res
);

  localparam int PL = MUL_LAT - 1;

  prod_t prod;
  logic  prod_neg;

  val_t             d_r   [1:PL];
  logic [VAL_W-1:0] rem_r [0:DIV_STEPS];
  logic [VAL_W-1:0] lo_r  [0:DIV_STEPS];
  logic [VAL_W-1:0] dm_r  [0:DIV_STEPS];
  logic             big_r [0:DIV_STEPS];
  logic             neg_r [0:DIV_STEPS];
  res_t             res_r;

  logic [VAL_W-1:0] dm;

  ldpm_mul #(.SHIFT(0)) u_prod (
    .clk      (clk),
    .en       (en),
    .a        (a),
    .b        (n),
    .prod     (prod),
    .prod_neg (prod_neg),
    .res      ()
  );

  assign dm = mag(d_r[PL]);

  // Quotient fits 64 bits only when the high product half is below the divisor.
  always_ff @(posedge clk) begin
    if (en) begin
      d_r[1] <= d;
      for (int k = 2; k <= PL; k++) begin
        d_r[k] <= d_r[k-1];
      end
      rem_r[0] <= prod[PROD_W-1:VAL_W];
      lo_r[0]  <= prod[VAL_W-1:0];
      dm_r[0]  <= dm;
      big_r[0] <= prod[PROD_W-1:VAL_W] >= dm;
      neg_r[0] <= prod_neg ^ d_r[PL][VAL_W-1];
      for (int i = 0; i < DIV_STEPS; i++) begin
        logic [VAL_W:0] tmp;
        logic           ge;
        tmp = {rem_r[i], lo_r[i][VAL_W-1]};
        ge  = tmp >= {1'b0, dm_r[i]};
        rem_r[i+1] <= ge ? VAL_W'(tmp - {1'b0, dm_r[i]}) : tmp[VAL_W-1:0];
        lo_r[i+1]  <= {lo_r[i][VAL_W-2:0], ge};
        dm_r[i+1]  <= dm_r[i];
        big_r[i+1] <= big_r[i];
        neg_r[i+1] <= neg_r[i];
      end
      res_r <= to_signed({{(VAL_W-1){1'b0}}, big_r[DIV_STEPS], lo_r[DIV_STEPS]},
                         neg_r[DIV_STEPS]);
    end
  end

  assign res = res_r;

endmodule

>>> rtl/lens_distortion_point_mapper.sv
`timescale 1ns / 1ps
// Lens distortion point mapper.
// Input channel in_valid/in_ready carries one point (in_coord_x, in_coord_y);
// result channel out_valid/out_ready returns one mapped point per input, in order,
// with out_saturated and out_divide_fault.
// direction_mode 0: normalized Q8.24 in, pixel Q16.16 out. 1: pixel in, normalized out.
// Registers sit on the APB-style port at byte address 8*index, 64-bit data;
// write them only while no point is in flight.
// The result comes through a chain of pipelined multipliers around a radix-2
// divider (64 one-bit steps).
// Throughput: one point per cycle while the output is not stalled.
// Every stage advances together; when out_valid is high and out_ready is low the
// whole pipeline holds and in_ready drops, so nothing is lost or repeated.
// Reset (rst_n low, synchronous) empties the pipeline and loads register defaults:
// forward mode, unit scales, zero center and zero coefficients.
// A zero radial denominator returns the largest positive value with both flags set.
`include "lens_distortion_point_mapper_macros.svh"
module lens_distortion_point_mapper import ldpm_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [COORD_W-1:0]    in_coord_x,
  input  logic [COORD_W-1:0]    in_coord_y,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [COORD_W-1:0]    out_x,
  output logic [COORD_W-1:0]    out_y,
  output logic                  out_saturated,
  output logic                  out_divide_fault,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int OUT_BITS = (COORD_WIDTH < COORD_W) ? COORD_WIDTH : COORD_W;
  localparam val_t CLAMP_HI = val_t'((longint'(1) <<< (OUT_BITS - 1)) - 1);
  localparam val_t CLAMP_LO = -CLAMP_HI - val_t'(1);
  localparam val_t ONE      = val_t'(longint'(1) <<< FRAC);

  localparam int S_X  = MUL_LAT;
  localparam int S_X2 = S_X + MUL_LAT;
  localparam int S_R2 = S_X2 + 1;
  localparam int S_B  = S_R2 + 1;
  localparam int S_R4 = S_R2 + MUL_LAT;
  localparam int S_T  = S_B + MUL_LAT;
  localparam int S_R6 = S_R4 + MUL_LAT;
  localparam int S_M2 = S_R6 + MUL_LAT;
  localparam int S_P1 = S_M2 + 1;
  localparam int S_P2 = S_P1 + 1;
  localparam int S_P3 = S_P2 + 1;
  localparam int S_Q  = S_P3 + DIV_LAT;
  localparam int S_D1 = S_Q + 1;
  localparam int S_D2 = S_D1 + 1;
  localparam int S_F  = S_D2 + MUL_LAT;
  localparam int S_V  = S_F + 1;
  localparam int S_O  = S_V + 1;

  function automatic res_t sadd(input val_t a, input val_t b);
    logic [VAL_W:0] s;
    res_t           r;
    s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
    if (s[VAL_W] != s[VAL_W-1]) begin
      r.val = s[VAL_W] ? VAL_MIN : VAL_MAX;
      r.sat = 1'b1;
    end else begin
      r.val = s[VAL_W-1:0];
      r.sat = 1'b0;
    end
    return r;
  endfunction

  function automatic val_t sx32(input logic [COORD_W-1:0] v);
    return {{(VAL_W-COORD_W){v[COORD_W-1]}}, v};
  endfunction

  function automatic val_t cf(input logic [COEF_W-1:0] f);
    return {{(VAL_W-COEF_W){f[COEF_W-1]}}, f};
  endfunction

  // Configuration registers
  logic                 mode_r;
  logic [SCALE_W-1:0]   su_r, sv_r;
  logic [COORD_W-1:0]   cu_r, cv_r;
  logic [3*COEF_W-1:0]  num_cfg_r, den_cfg_r;
  logic [2*COEF_W-1:0]  tan_r;
  reg_idx_t             cfg_idx;
  logic                 cfg_wr;

  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_t'(paddr[CFG_ADDR_W-1:CFG_IDX_LSB]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= 1'b0;
      su_r      <= SCALE_W'(longint'(1) <<< FRAC);
      sv_r      <= SCALE_W'(longint'(1) <<< FRAC);
      cu_r      <= '0;
      cv_r      <= '0;
      num_cfg_r <= '0;
      den_cfg_r <= '0;
      tan_r     <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_MODE:       mode_r    <= pwdata[0];
        REG_SCALE_U:    su_r      <= pwdata[SCALE_W-1:0];
        REG_SCALE_V:    sv_r      <= pwdata[SCALE_W-1:0];
        REG_CENTER_U:   cu_r      <= pwdata[COORD_W-1:0];
        REG_CENTER_V:   cv_r      <= pwdata[COORD_W-1:0];
        REG_RADIAL_NUM: num_cfg_r <= pwdata[3*COEF_W-1:0];
        REG_RADIAL_DEN: den_cfg_r <= pwdata[3*COEF_W-1:0];
        REG_TANGENTIAL: tan_r     <= pwdata[2*COEF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_MODE:       prdata = CFG_DATA_W'(mode_r);
      REG_SCALE_U:    prdata = CFG_DATA_W'(su_r);
      REG_SCALE_V:    prdata = CFG_DATA_W'(sv_r);
      REG_CENTER_U:   prdata = CFG_DATA_W'(cu_r);
      REG_CENTER_V:   prdata = CFG_DATA_W'(cv_r);
      REG_RADIAL_NUM: prdata = CFG_DATA_W'(num_cfg_r);
      REG_RADIAL_DEN: prdata = CFG_DATA_W'(den_cfg_r);
      REG_TANGENTIAL: prdata = CFG_DATA_W'(tan_r);
      default:        prdata = '0;
    endcase
  end

  val_t su_v, sv_v, n1, n2, n3, d1, d2, d3, p1, p2;
  assign su_v = val_t'(su_r);
  assign sv_v = val_t'(sv_r);
  assign n1   = cf(num_cfg_r[COEF_W-1:0]);
  assign n2   = cf(num_cfg_r[2*COEF_W-1:COEF_W]);
  assign n3   = cf(num_cfg_r[3*COEF_W-1:2*COEF_W]);
  assign d1   = cf(den_cfg_r[COEF_W-1:0]);
  assign d2   = cf(den_cfg_r[2*COEF_W-1:COEF_W]);
  assign d3   = cf(den_cfg_r[3*COEF_W-1:2*COEF_W]);
  assign p1   = cf(tan_r[COEF_W-1:0]);
  assign p2   = cf(tan_r[2*COEF_W-1:COEF_W]);

  // Pipeline
  logic en;
  logic v_r   [0:S_O];
  logic sat_r [0:S_V];
  logic [S_O:0] sat_new;

  logic [COORD_W-1:0] cx_r [0:S_X];
  logic [COORD_W-1:0] cy_r [0:S_X];
  val_t x_r   [S_X+1:S_P3];
  val_t y_r   [S_X+1:S_P3];
  val_t xy_r  [S_X2+1:S_B];
  val_t r2_r  [S_R2:S_R4];
  val_t ax_r, ay_r, bx_r, by_r;
  val_t m0n_r [S_R4+1:S_M2];
  val_t m0d_r [S_R4+1:S_M2];
  val_t m1n_r [S_R6+1:S_P1];
  val_t m1d_r [S_R6+1:S_P1];
  val_t m2n_r [S_M2+1:S_P2];
  val_t m2d_r [S_M2+1:S_P2];
  val_t num_r [S_P1:S_P3];
  val_t den_r [S_P1:S_P3];
  val_t t1x_r [S_T+1:S_Q];
  val_t t1y_r [S_T+1:S_Q];
  val_t t2x_r [S_T+1:S_D1];
  val_t t2y_r [S_T+1:S_D1];
  logic dz_r  [S_P3+1:S_V];
  val_t xd_r  [S_D1:S_F];
  val_t yd_r  [S_D1:S_F];
  val_t vx_r, vy_r;
  logic [COORD_W-1:0] out_x_r, out_y_r;
  logic out_sat_r, out_dz_r;

  res_t mx, my, x2, y2, xy, r4, m0n, m0d, r6, m1n, m1d, m2n, m2d;
  res_t t1x, t2x, t1y, t2y, qx, qy, fx, fy;
  res_t r2s, axs, ays, bxs, bys, p1n, p1d, p2n, p2d, p3n, p3d;
  res_t e1x, e1y, e2x, e2y, gx, gy, cxr, cyr;
  val_t x_c, y_c;
  val_t vx_c, vy_c;

  assign en        = !v_r[S_O] || out_ready;
  assign in_ready  = en;
  assign out_valid = v_r[S_O];

  ldpm_mul #(.SHIFT(16)) u_mx (.clk(clk), .en(en),
    .a(sx32(cx_r[0]) - sx32(cu_r)), .b(su_v), .prod(), .prod_neg(), .res(mx));
  ldpm_mul #(.SHIFT(16)) u_my (.clk(clk), .en(en),
    .a(sx32(cy_r[0]) - sx32(cv_r)), .b(sv_v), .prod(), .prod_neg(), .res(my));

  assign x_c = mode_r ? mx.val : (sx32(cx_r[S_X]) <<< 8);
  assign y_c = mode_r ? my.val : (sx32(cy_r[S_X]) <<< 8);

  ldpm_mul #(.SHIFT(FRAC)) u_x2 (.clk(clk), .en(en), .a(x_c), .b(x_c),
    .prod(), .prod_neg(), .res(x2));
  ldpm_mul #(.SHIFT(FRAC)) u_y2 (.clk(clk), .en(en), .a(y_c), .b(y_c),
    .prod(), .prod_neg(), .res(y2));
  ldpm_mul #(.SHIFT(FRAC)) u_xy (.clk(clk), .en(en), .a(x_c), .b(y_c),
    .prod(), .prod_neg(), .res(xy));

  assign r2s = sadd(x2.val, y2.val);
  assign axs = sadd(x2.val, x2.val);
  assign ays = sadd(y2.val, y2.val);
  assign bxs = sadd(r2_r[S_R2], ax_r);
  assign bys = sadd(r2_r[S_R2], ay_r);

  ldpm_mul #(.SHIFT(FRAC)) u_r4 (.clk(clk), .en(en), .a(r2_r[S_R2]), .b(r2_r[S_R2]),
    .prod(), .prod_neg(), .res(r4));
  ldpm_mul #(.SHIFT(16)) u_m0n (.clk(clk), .en(en), .a(n1), .b(r2_r[S_R2]),
    .prod(), .prod_neg(), .res(m0n));
  ldpm_mul #(.SHIFT(16)) u_m0d (.clk(clk), .en(en), .a(d1), .b(r2_r[S_R2]),
    .prod(), .prod_neg(), .res(m0d));

  ldpm_mul #(.SHIFT(15)) u_t1x (.clk(clk), .en(en), .a(p1), .b(xy_r[S_B]),
    .prod(), .prod_neg(), .res(t1x));
  ldpm_mul #(.SHIFT(16)) u_t2x (.clk(clk), .en(en), .a(p2), .b(bx_r),
    .prod(), .prod_neg(), .res(t2x));
  ldpm_mul #(.SHIFT(16)) u_t1y (.clk(clk), .en(en), .a(p1), .b(by_r),
    .prod(), .prod_neg(), .res(t1y));
  ldpm_mul #(.SHIFT(15)) u_t2y (.clk(clk), .en(en), .a(p2), .b(xy_r[S_B]),
    .prod(), .prod_neg(), .res(t2y));

  ldpm_mul #(.SHIFT(FRAC)) u_r6 (.clk(clk), .en(en), .a(r4.val), .b(r2_r[S_R4]),
    .prod(), .prod_neg(), .res(r6));
  ldpm_mul #(.SHIFT(16)) u_m1n (.clk(clk), .en(en), .a(n2), .b(r4.val),
    .prod(), .prod_neg(), .res(m1n));
  ldpm_mul #(.SHIFT(16)) u_m1d (.clk(clk), .en(en), .a(d2), .b(r4.val),
    .prod(), .prod_neg(), .res(m1d));

  ldpm_mul #(.SHIFT(16)) u_m2n (.clk(clk), .en(en), .a(n3), .b(r6.val),
    .prod(), .prod_neg(), .res(m2n));
  ldpm_mul #(.SHIFT(16)) u_m2d (.clk(clk), .en(en), .a(d3), .b(r6.val),
    .prod(), .prod_neg(), .res(m2d));

  assign p1n = sadd(ONE, m0n_r[S_M2]);
  assign p1d = sadd(ONE, m0d_r[S_M2]);
  assign p2n = sadd(num_r[S_P1], m1n_r[S_P1]);
  assign p2d = sadd(den_r[S_P1], m1d_r[S_P1]);
  assign p3n = sadd(num_r[S_P2], m2n_r[S_P2]);
  assign p3d = sadd(den_r[S_P2], m2d_r[S_P2]);

  ldpm_div u_divx (.clk(clk), .en(en), .a(x_r[S_P3]), .n(num_r[S_P3]),
    .d(den_r[S_P3]), .res(qx));
  ldpm_div u_divy (.clk(clk), .en(en), .a(y_r[S_P3]), .n(num_r[S_P3]),
    .d(den_r[S_P3]), .res(qy));

  assign e1x = sadd(qx.val, t1x_r[S_Q]);
  assign e1y = sadd(qy.val, t1y_r[S_Q]);
  assign e2x = sadd(xd_r[S_D1], t2x_r[S_D1]);
  assign e2y = sadd(yd_r[S_D1], t2y_r[S_D1]);

  ldpm_mul #(.SHIFT(48)) u_fx (.clk(clk), .en(en), .a(xd_r[S_D2]), .b(su_v),
    .prod(), .prod_neg(), .res(fx));
  ldpm_mul #(.SHIFT(48)) u_fy (.clk(clk), .en(en), .a(yd_r[S_D2]), .b(sv_v),
    .prod(), .prod_neg(), .res(fy));

  assign gx   = sadd(fx.val, sx32(cu_r));
  assign gy   = sadd(fy.val, sx32(cv_r));
  assign vx_c = mode_r ? (xd_r[S_F] >>> 8) : gx.val;
  assign vy_c = mode_r ? (yd_r[S_F] >>> 8) : gy.val;

  always_comb begin
    cxr = '{val: vx_r, sat: 1'b0};
    cyr = '{val: vy_r, sat: 1'b0};
    if (vx_r > CLAMP_HI) cxr = '{val: CLAMP_HI, sat: 1'b1};
    if (vx_r < CLAMP_LO) cxr = '{val: CLAMP_LO, sat: 1'b1};
    if (vy_r > CLAMP_HI) cyr = '{val: CLAMP_HI, sat: 1'b1};
    if (vy_r < CLAMP_LO) cyr = '{val: CLAMP_LO, sat: 1'b1};
  end

  // Saturation events joined into the flag at the stage where they are registered
  always_comb begin
    sat_new          = '0;
    sat_new[S_X+1]  |= mode_r && (mx.sat || my.sat);
    sat_new[S_R2]   |= x2.sat || y2.sat || xy.sat || r2s.sat || axs.sat || ays.sat;
    sat_new[S_B]    |= bxs.sat || bys.sat;
    sat_new[S_R4+1] |= r4.sat || m0n.sat || m0d.sat;
    sat_new[S_T+1]  |= t1x.sat || t2x.sat || t1y.sat || t2y.sat;
    sat_new[S_R6+1] |= r6.sat || m1n.sat || m1d.sat;
    sat_new[S_P1]   |= m2n.sat || m2d.sat || p1n.sat || p1d.sat;
    sat_new[S_P2]   |= p2n.sat || p2d.sat;
    sat_new[S_P3]   |= p3n.sat || p3d.sat;
    sat_new[S_D1]   |= qx.sat || qy.sat || e1x.sat || e1y.sat;
    sat_new[S_D2]   |= e2x.sat || e2y.sat;
    sat_new[S_V]    |= !mode_r && (fx.sat || fy.sat || gx.sat || gy.sat);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= S_O; k++) begin
        v_r[k] <= 1'b0;
      end
    end else if (en) begin
      v_r[0] <= in_valid;
      for (int k = 1; k <= S_O; k++) begin
        v_r[k] <= v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sat_r[0] <= 1'b0;
      for (int k = 1; k <= S_V; k++) begin
        sat_r[k] <= sat_r[k-1] || sat_new[k];
      end
      cx_r[0] <= in_coord_x;
      cy_r[0] <= in_coord_y;
      for (int k = 1; k <= S_X; k++) begin
        cx_r[k] <= cx_r[k-1];
        cy_r[k] <= cy_r[k-1];
      end
      x_r[S_X+1] <= x_c;
      y_r[S_X+1] <= y_c;
      for (int k = S_X+2; k <= S_P3; k++) begin
        x_r[k] <= x_r[k-1];
        y_r[k] <= y_r[k-1];
      end
      xy_r[S_X2+1] <= xy.val;
      for (int k = S_X2+2; k <= S_B; k++) begin
        xy_r[k] <= xy_r[k-1];
      end
      r2_r[S_R2] <= r2s.val;
      for (int k = S_R2+1; k <= S_R4; k++) begin
        r2_r[k] <= r2_r[k-1];
      end
      ax_r <= axs.val;
      ay_r <= ays.val;
      bx_r <= bxs.val;
      by_r <= bys.val;
      m0n_r[S_R4+1] <= m0n.val;
      m0d_r[S_R4+1] <= m0d.val;
      for (int k = S_R4+2; k <= S_M2; k++) begin
        m0n_r[k] <= m0n_r[k-1];
        m0d_r[k] <= m0d_r[k-1];
      end
      m1n_r[S_R6+1] <= m1n.val;
      m1d_r[S_R6+1] <= m1d.val;
      for (int k = S_R6+2; k <= S_P1; k++) begin
        m1n_r[k] <= m1n_r[k-1];
        m1d_r[k] <= m1d_r[k-1];
      end
      m2n_r[S_M2+1] <= m2n.val;
      m2d_r[S_M2+1] <= m2d.val;
      for (int k = S_M2+2; k <= S_P2; k++) begin
        m2n_r[k] <= m2n_r[k-1];
        m2d_r[k] <= m2d_r[k-1];
      end
      num_r[S_P1] <= p1n.val;
      den_r[S_P1] <= p1d.val;
      num_r[S_P2] <= p2n.val;
      den_r[S_P2] <= p2d.val;
      num_r[S_P3] <= p3n.val;
      den_r[S_P3] <= p3d.val;
      t1x_r[S_T+1] <= t1x.val;
      t1y_r[S_T+1] <= t1y.val;
      t2x_r[S_T+1] <= t2x.val;
      t2y_r[S_T+1] <= t2y.val;
      for (int k = S_T+2; k <= S_Q; k++) begin
        t1x_r[k] <= t1x_r[k-1];
        t1y_r[k] <= t1y_r[k-1];
      end
      for (int k = S_T+2; k <= S_D1; k++) begin
        t2x_r[k] <= t2x_r[k-1];
        t2y_r[k] <= t2y_r[k-1];
      end
      dz_r[S_P3+1] <= (den_r[S_P3] == '0);
      for (int k = S_P3+2; k <= S_V; k++) begin
        dz_r[k] <= dz_r[k-1];
      end
      xd_r[S_D1] <= e1x.val;
      yd_r[S_D1] <= e1y.val;
      xd_r[S_D2] <= e2x.val;
      yd_r[S_D2] <= e2y.val;
      for (int k = S_D2+1; k <= S_F; k++) begin
        xd_r[k] <= xd_r[k-1];
        yd_r[k] <= yd_r[k-1];
      end
      vx_r <= vx_c;
      vy_r <= vy_c;
      out_x_r   <= dz_r[S_V] ? CLAMP_HI[COORD_W-1:0] : cxr.val[COORD_W-1:0];
      out_y_r   <= dz_r[S_V] ? CLAMP_HI[COORD_W-1:0] : cyr.val[COORD_W-1:0];
      out_sat_r <= dz_r[S_V] || sat_r[S_V] || cxr.sat || cyr.sat;
      out_dz_r  <= dz_r[S_V];
    end
  end

  assign out_x            = out_x_r;
  assign out_y            = out_y_r;
  assign out_saturated    = out_sat_r;
  assign out_divide_fault = out_dz_r;

  `LDPM_ASSERT(a_fault_sat, out_valid && out_divide_fault |-> out_saturated, "fault without sat")
  `LDPM_ASSERT(a_fault_val, out_valid && out_divide_fault |-> (out_x == CLAMP_HI[COORD_W-1:0]) && (out_y == CLAMP_HI[COORD_W-1:0]), "fault value")
  `LDPM_ASSERT_RST(a_rst_empty, !rst_n |=> !out_valid, "valid after reset")

endmodule
